// File: rtl/nnrf_pkg.sv
// nnrf_pkg: shared types and constants for the N-run filter and line wrapper
// used by nnrf_regs, nnrf_core, nnrf_resq and the top level
// no dependencies
package nnrf_pkg;

	localparam logic [1:0] KIND_BASE    = 2'd0;
	localparam logic [1:0] KIND_NEWLINE = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_EOR  = 1'b1;

	localparam logic REG_MAX_N_RUN  = 1'b0;
	localparam logic REG_LINE_WIDTH = 1'b1;

	localparam logic [15:0] MAX_N_RUN_RST  = 16'd10;
	localparam logic [7:0]  LINE_WIDTH_RST = 8'd75;

	localparam logic [16:0] NRUN_SAT     = 17'h1FFFF;
	localparam logic [7:0]  NEWLINE_BYTE = 8'd10;

	// result queue depth, must be a power of two and at least two
	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = $clog2(RQ_DEPTH);

	typedef struct packed {
		logic [15:0] max_n_run;
		logic [7:0]  line_width;
	} cfg_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] ch;
		logic       last;
	} res_t;

	// up to two results produced by one item
	typedef struct packed {
		logic [1:0] cnt;
		res_t       res0;
		res_t       res1;
	} push_t;

endpackage

// File: rtl/nucleotide_n_run_filter_wrap.sv
// nucleotide_n_run_filter_wrap: N-run filter and line wrapper, top level
// channels: input word (op, chr), result word (kind, out_char, last),
// APB-style config port with max_n_run at 0x0 and line_width at 0x4.
// each accepted word is registered, then classified against the N-run counter,
// line fill and sticky error, giving zero, one or two result
// words into a four-entry result queue that feeds the output.
// a word passes through the input register and then the result queue, whose
// nonzero count raises out_valid with the first result.
// throughput: one input word per cycle while the result queue has room for two
// more words; a word that wraps a line yields two results, which leave one at a
// time through the single queue read port.
// in_ready drops only while the input register holds a word and the queue
// cannot take two more words, so a stalled receiver backs up into the input
// register and then in_ready.
// reset clears the counters, the error flag, the queue and loads the config
// defaults (max_n_run 10, line_width 75); results in flight are discarded.
// the user must write config only while no word is in flight; the block does not enforce this.
// depends on nnrf_pkg, nnrf_regs, nnrf_core, nnrf_resq
module nucleotide_n_run_filter_wrap (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [7:0]  chr,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  out_char,
	output logic        last
);

	nnrf_pkg::cfg_t  cfg;
	nnrf_pkg::push_t push;
	nnrf_pkg::res_t  out_res;
	logic            room;

	nnrf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	nnrf_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.chr      (chr),
		.room     (room),
		.push     (push)
	);

	nnrf_resq u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign kind     = out_res.kind;
	assign out_char = out_res.ch;
	assign last     = out_res.last;

endmodule

// File: rtl/nnrf_regs.sv
// nnrf_regs: APB-style configuration registers (max_n_run, line_width)
// depends on nnrf_pkg
module nnrf_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output nnrf_pkg::cfg_t      cfg
);

	logic [15:0] max_n_run_q;
	logic [7:0]  line_width_q;
	logic        wr_en;
	logic        reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_n_run_q  <= nnrf_pkg::MAX_N_RUN_RST;
			line_width_q <= nnrf_pkg::LINE_WIDTH_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				nnrf_pkg::REG_MAX_N_RUN:  max_n_run_q  <= pwdata[15:0];
				nnrf_pkg::REG_LINE_WIDTH: line_width_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			nnrf_pkg::REG_MAX_N_RUN:  prdata = {16'd0, max_n_run_q};
			nnrf_pkg::REG_LINE_WIDTH: prdata = {24'd0, line_width_q};
			default:                  prdata = 32'd0;
		endcase
	end

	assign cfg.max_n_run  = max_n_run_q;
	assign cfg.line_width = line_width_q;

endmodule

// File: rtl/nnrf_core.sv
// nnrf_core: input word register, run/line/error state and result generation
// depends on nnrf_pkg
module nnrf_core (
	input  logic                clk,
	input  logic                arst_n,
	input  nnrf_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                op,
	input  logic [7:0]          chr,
	input  logic                room,
	output nnrf_pkg::push_t     push
);

	logic        valid_s1;
	logic        op_s1;
	logic [7:0]  chr_s1;
	logic [16:0] nrun_q;
	logic [7:0]  fill_q;
	logic        err_q;

	logic        advance;
	logic        blank;
	logic [7:0]  upc;
	logic        is_base;
	logic        is_n;
	logic [16:0] nrun_inc;
	logic        pass;
	logic [8:0]  fill_inc;
	logic [8:0]  width9;
	logic        wrap;

	logic [16:0] nrun_d;
	logic [7:0]  fill_d;
	logic        err_d;
	nnrf_pkg::push_t push_d;

	assign advance  = valid_s1 & room;
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1  <= op;
			chr_s1 <= chr;
		end
	end

	// character classes
	assign blank   = (chr_s1 == 8'd32) || (chr_s1 >= 8'd9 && chr_s1 <= 8'd13);
	assign upc     = (chr_s1 >= 8'h61 && chr_s1 <= 8'h7A) ? chr_s1 - 8'd32 : chr_s1;
	assign is_base = (upc == 8'h41) || (upc == 8'h43) || (upc == 8'h47) ||
			 (upc == 8'h54) || (upc == 8'h55);
	assign is_n    = (upc == 8'h4E);

	assign nrun_inc = (nrun_q == nnrf_pkg::NRUN_SAT) ? nrun_q : nrun_q + 17'd1;
	assign pass     = is_base | (is_n & (nrun_inc <= {1'b0, cfg.max_n_run}));

	// width zero means a full 256-base line
	assign fill_inc = {1'b0, fill_q} + 9'd1;
	assign width9   = (cfg.line_width == 8'd0) ? 9'd256 : {1'b0, cfg.line_width};
	assign wrap     = fill_inc >= width9;

	always_comb begin
		nrun_d = nrun_q;
		fill_d = fill_q;
		err_d  = err_q;
		push_d.cnt       = 2'd0;
		push_d.res0.kind = nnrf_pkg::KIND_BASE;
		push_d.res0.ch   = chr_s1;
		push_d.res0.last = 1'b1;
		push_d.res1.kind = nnrf_pkg::KIND_NEWLINE;
		push_d.res1.ch   = nnrf_pkg::NEWLINE_BYTE;
		push_d.res1.last = 1'b1;
		if (err_q) begin
			push_d.cnt       = 2'd1;
			push_d.res0.kind = nnrf_pkg::KIND_ERROR;
			push_d.res0.ch   = (op_s1 == nnrf_pkg::OP_CHAR) ? chr_s1 : 8'd0;
		end else if (op_s1 == nnrf_pkg::OP_EOR) begin
			// close a partial line only
			if (fill_q != 8'd0) begin
				fill_d           = 8'd0;
				push_d.cnt       = 2'd1;
				push_d.res0.kind = nnrf_pkg::KIND_NEWLINE;
				push_d.res0.ch   = nnrf_pkg::NEWLINE_BYTE;
			end
		end else if (blank) begin
			push_d.cnt = 2'd0;
		end else if (is_base || is_n) begin
			nrun_d = is_n ? nrun_inc : 17'd0;
			if (pass) begin
				push_d.res0.last = ~wrap;
				if (wrap) begin
					push_d.cnt = 2'd2;
					fill_d     = 8'd0;
				end else begin
					push_d.cnt = 2'd1;
					fill_d     = fill_inc[7:0];
				end
			end
		end else begin
			err_d            = 1'b1;
			push_d.cnt       = 2'd1;
			push_d.res0.kind = nnrf_pkg::KIND_ERROR;
		end
		if (!advance) begin
			push_d.cnt = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nrun_q <= 17'd0;
			fill_q <= 8'd0;
			err_q  <= 1'b0;
		end else if (advance) begin
			nrun_q <= nrun_d;
			fill_q <= fill_d;
			err_q  <= err_d;
		end
	end

	assign push = push_d;

endmodule

// File: rtl/nnrf_resq.sv
// nnrf_resq: small result queue taking up to two words per cycle, giving one
// depends on nnrf_pkg
module nnrf_resq (
	input  logic                clk,
	input  logic                arst_n,
	input  nnrf_pkg::push_t     push,
	output logic                room,
	output logic                out_valid,
	input  logic                out_ready,
	output nnrf_pkg::res_t      out_res
);

	nnrf_pkg::res_t mem [nnrf_pkg::RQ_DEPTH];

	logic [nnrf_pkg::RQ_AW-1:0] wp_q;
	logic [nnrf_pkg::RQ_AW-1:0] rp_q;
	logic [nnrf_pkg::RQ_AW:0]   count_q;
	logic                       pop;
	logic [nnrf_pkg::RQ_AW-1:0] wp_nxt;

	localparam logic [nnrf_pkg::RQ_AW:0] ROOM_LIM = (nnrf_pkg::RQ_AW + 1)'(nnrf_pkg::RQ_DEPTH - 2);

	assign wp_nxt    = wp_q + nnrf_pkg::RQ_AW'(1);
	assign out_valid = count_q != '0;
	assign pop       = out_valid & out_ready;
	// room for two words, counting the one leaving this cycle
	assign room      = (count_q <= ROOM_LIM) || (pop && count_q == ROOM_LIM + 1'b1);
	assign out_res   = mem[rp_q];

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem[wp_q] <= push.res0;
		end
		if (push.cnt == 2'd2) begin
			mem[wp_nxt] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + nnrf_pkg::RQ_AW'(push.cnt);
			if (pop) begin
				rp_q <= rp_q + nnrf_pkg::RQ_AW'(1);
			end
			count_q <= count_q + (nnrf_pkg::RQ_AW + 1)'(push.cnt)
				   - (nnrf_pkg::RQ_AW + 1)'(pop);
		end
	end

endmodule

// File: verif/testbench.sv
// testbench for nucleotide_n_run_filter_wrap: directed table, long N-run burst,
// random phases over several register settings and pacing modes, sticky error tail
// depends on nnrf_pkg and the nucleotide_n_run_filter_wrap top level
`timescale 1ns / 1ps

module testbench;

	typedef nnrf_pkg::res_t res_t;

	localparam logic [1:0]  KIND_BASE      = nnrf_pkg::KIND_BASE;
	localparam logic [1:0]  KIND_NEWLINE   = nnrf_pkg::KIND_NEWLINE;
	localparam logic [1:0]  KIND_ERROR     = nnrf_pkg::KIND_ERROR;
	localparam logic        OP_CHAR        = nnrf_pkg::OP_CHAR;
	localparam logic        OP_EOR         = nnrf_pkg::OP_EOR;
	localparam logic        REG_MAX_N_RUN  = nnrf_pkg::REG_MAX_N_RUN;
	localparam logic        REG_LINE_WIDTH = nnrf_pkg::REG_LINE_WIDTH;
	localparam logic [15:0] MAX_N_RUN_RST  = nnrf_pkg::MAX_N_RUN_RST;
	localparam logic [7:0]  LINE_WIDTH_RST = nnrf_pkg::LINE_WIDTH_RST;
	localparam logic [16:0] NRUN_SAT       = nnrf_pkg::NRUN_SAT;
	localparam logic [7:0]  NEWLINE_BYTE   = nnrf_pkg::NEWLINE_BYTE;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 6;
	localparam int MAX_GAP        = 24;
	localparam int N_BURST        = 30;

	localparam logic [2:0] ADDR_MAX_N_RUN  = {REG_MAX_N_RUN, 2'b00};
	localparam logic [2:0] ADDR_LINE_WIDTH = {REG_LINE_WIDTH, 2'b00};

	localparam logic [7:0] CH_UPPER_N = "N";
	localparam logic [7:0] CH_LOWER_N = "n";

	typedef enum logic {ROW_ITEM, ROW_CFG} row_e;
	typedef enum int {PACE_NONE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_e;

	typedef struct packed {
		row_e        act;
		logic        op;
		logic [7:0]  ch;
		logic [2:0]  addr;
		logic [31:0] wdata;
		logic        typed;
		logic [1:0]  kind;
		logic [7:0]  want_ch;
	} row_t;

	localparam int OPEN_ROWS  = 29;
	localparam int TOTAL_ROWS = 36;

	// typed rows carry a single result with last set
	row_t stim_rows [0:TOTAL_ROWS-1] = '{
		'{ROW_ITEM, OP_EOR,  8'h00, 3'd0, 32'd0, 1'b0, KIND_BASE, 8'h00},
		'{ROW_ITEM, OP_CHAR, "A",   3'd0, 32'd0, 1'b1, KIND_BASE, "A"},
		'{ROW_ITEM, OP_CHAR, "c",   3'd0, 32'd0, 1'b1, KIND_BASE, "c"},
		'{ROW_ITEM, OP_CHAR, "G",   3'd0, 32'd0, 1'b0, KIND_BASE, 8'h00},
		'{ROW_ITEM, OP_CHAR, "t",   3'd0, 32'd0, 1'b0, KIND_BASE, 8'h00},
		'{ROW_ITEM, OP_CHAR, "U",   3'd0, 32'd0, 1'b0, KIND_BASE, 8'h00},
		'{ROW_ITEM, OP_CHAR, "a",   3'd0, 32'd0, 1'b0, KIND_BASE, 8'h00},
		'{ROW_ITEM, OP_CHAR, "C",   3'd0, 32'd0, 1'b0, KIND_BASE, 8'h00},
		'{ROW_ITEM, OP_CHAR, "g",   3'd0, 32'd0, 1'b0, KIND_BASE, 8'h00},
		'{ROW_ITEM, OP_CHAR, "T",   3'd0, 32'd0, 1'b0, KIND_BASE, 8'h00},
		'{ROW_ITEM, OP_CHAR, "u",   3'd0, 32'd0, 1'b0, KIND_BASE, 8'h00},
		'{ROW_ITEM, OP_CHAR, 8'd9,  3'd0, 32'd0, 1'b0, KIND_BASE, 8'h00},
		'{ROW_ITEM, OP_CHAR, 8'd13, 3'd0, 32'd0, 1'b0, KIND_BASE, 8'h00},
		'{ROW_ITEM, OP_CHAR, 8'd32, 3'd0, 32'd0, 1'b0, KIND_BASE, 8'h00},
		'{ROW_ITEM, OP_EOR,  8'hFF, 3'd0, 32'd0, 1'b1, KIND_NEWLINE, NEWLINE_BYTE},
		'{ROW_CFG,  OP_CHAR, 8'h00, ADDR_LINE_WIDTH, 32'd1, 1'b0, KIND_BASE, 8'h00},
		'{ROW_ITEM, OP_CHAR, "A",   3'd0, 32'd0, 1'b0, KIND_BASE, 8'h00},
		'{ROW_CFG,  OP_CHAR, 8'h00, ADDR_MAX_N_RUN, 32'd0, 1'b0, KIND_BASE, 8'h00},
		'{ROW_ITEM, OP_CHAR, "N",   3'd0, 32'd0, 1'b0, KIND_BASE, 8'h00},
		'{ROW_ITEM, OP_CHAR, "n",   3'd0, 32'd0, 1'b0, KIND_BASE, 8'h00},
		'{ROW_ITEM, OP_CHAR, "A",   3'd0, 32'd0, 1'b0, KIND_BASE, 8'h00},
		'{ROW_CFG,  OP_CHAR, 8'h00, ADDR_MAX_N_RUN, 32'd2, 1'b0, KIND_BASE, 8'h00},
		'{ROW_CFG,  OP_CHAR, 8'h00, ADDR_LINE_WIDTH, 32'd255, 1'b0, KIND_BASE, 8'h00},
		'{ROW_ITEM, OP_CHAR, "N",   3'd0, 32'd0, 1'b0, KIND_BASE, 8'h00},
		'{ROW_ITEM, OP_CHAR, "n",   3'd0, 32'd0, 1'b0, KIND_BASE, 8'h00},
		'{ROW_ITEM, OP_CHAR, "N",   3'd0, 32'd0, 1'b0, KIND_BASE, 8'h00},
		'{ROW_ITEM, OP_CHAR, "C",   3'd0, 32'd0, 1'b0, KIND_BASE, 8'h00},
		// width drops below the current fill
		'{ROW_CFG,  OP_CHAR, 8'h00, ADDR_LINE_WIDTH, 32'd2, 1'b0, KIND_BASE, 8'h00},
		'{ROW_ITEM, OP_CHAR, "G",   3'd0, 32'd0, 1'b0, KIND_BASE, 8'h00},
		// closing rows: error latches and sticks
		'{ROW_ITEM, OP_CHAR, "A",   3'd0, 32'd0, 1'b0, KIND_BASE, 8'h00},
		'{ROW_ITEM, OP_CHAR, 8'd200, 3'd0, 32'd0, 1'b1, KIND_ERROR, 8'd200},
		'{ROW_ITEM, OP_CHAR, "X",   3'd0, 32'd0, 1'b1, KIND_ERROR, "X"},
		'{ROW_ITEM, OP_EOR,  8'hA5, 3'd0, 32'd0, 1'b1, KIND_ERROR, 8'h00},
		'{ROW_ITEM, OP_CHAR, 8'd32, 3'd0, 32'd0, 1'b1, KIND_ERROR, 8'd32},
		'{ROW_ITEM, OP_CHAR, "N",   3'd0, 32'd0, 1'b1, KIND_ERROR, "N"},
		'{ROW_ITEM, OP_CHAR, 8'd255, 3'd0, 32'd0, 1'b1, KIND_ERROR, 8'd255}
	};

	localparam logic [7:0] BASES  [0:9] = '{"A", "C", "G", "T", "U", "a", "c", "g", "t", "u"};
	localparam logic [7:0] BLANKS [0:5] = '{8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd32};

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [2:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic        op        = OP_CHAR;
	logic [7:0]  chr       = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  out_char;
	logic        last;

	// filter state mirrored from the block
	logic [16:0] n_run;
	logic [7:0]  line_fill;
	logic        err_stuck;
	logic [15:0] cfg_max_n;
	logic [7:0]  cfg_width;

	res_t        expected_out [$];
	res_t        head;
	int          mismatches = 0;
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          idle_cycles = 0;
	int          n_left = 0;
	int          eor_pct = 10;

	nucleotide_n_run_filter_wrap dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_valid, .in_ready, .op, .chr, .out_valid, .out_ready, .kind, .out_char, .last
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int place_base(input logic [7:0] c, output res_t r0, output res_t r1);
		int next_fill;
		int width;
		next_fill = int'(line_fill) + 1;
		width = (cfg_width == 8'd0) ? 256 : int'(cfg_width);
		r0 = '{kind: KIND_BASE, ch: c, last: 1'b1};
		r1 = '0;
		if (next_fill >= width || next_fill >= 256) begin
			line_fill = '0;
			r0.last = 1'b0;
			r1 = '{kind: KIND_NEWLINE, ch: NEWLINE_BYTE, last: 1'b1};
			return 2;
		end
		line_fill = next_fill[7:0];
		return 1;
	endfunction

	function automatic int filter_and_wrap(input logic o, input logic [7:0] c,
			output res_t r0, output res_t r1);
		logic [7:0] upper;
		r0 = '0;
		r1 = '0;
		if (err_stuck) begin
			r0 = '{kind: KIND_ERROR, ch: (o == OP_CHAR) ? c : 8'h00, last: 1'b1};
			return 1;
		end
		if (o == OP_EOR) begin
			if (line_fill == 8'd0)
				return 0;
			line_fill = '0;
			r0 = '{kind: KIND_NEWLINE, ch: NEWLINE_BYTE, last: 1'b1};
			return 1;
		end
		if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13))
			return 0;
		upper = (c >= "a" && c <= "z") ? c - 8'd32 : c;
		if (upper == "A" || upper == "C" || upper == "G" || upper == "T" || upper == "U") begin
			n_run = '0;
			return place_base(c, r0, r1);
		end
		if (c == CH_UPPER_N || c == CH_LOWER_N) begin
			if (n_run < NRUN_SAT)
				n_run = n_run + 17'd1;
			if (n_run <= {1'b0, cfg_max_n})
				return place_base(c, r0, r1);
			return 0;
		end
		err_stuck = 1'b1;
		r0 = '{kind: KIND_ERROR, ch: c, last: 1'b1};
		return 1;
	endfunction

	task automatic set_pacing(input pace_e mode);
		case (mode)
			PACE_NONE: begin
				idle_pct = 0;
				stall_pct = 0;
			end
			PACE_SENDER: begin
				idle_pct = 62;
				stall_pct = 0;
			end
			PACE_RECEIVER: begin
				idle_pct = 0;
				stall_pct = 62;
			end
			default: begin
				idle_pct = 23;
				stall_pct = 23;
			end
		endcase
	endtask

	task automatic send_item(input logic o, input logic [7:0] c, input logic typed,
			input res_t want, output int n);
		int gap;
		res_t r0;
		res_t r1;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		chr <= c;
		do @(posedge clk); while (!in_ready);
		n = filter_and_wrap(o, c, r0, r1);
		if (typed) begin
			expected_out.push_back(want);
		end else begin
			if (n > 0)
				expected_out.push_back(r0);
			if (n > 1)
				expected_out.push_back(r1);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_out.size() != 0)
			@(posedge clk);
	endtask

	// words that give no result may still be in flight after the queue empties
	task automatic settle();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] a, input logic [31:0] d);
		settle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (a == ADDR_MAX_N_RUN)
			cfg_max_n = d[15:0];
		else
			cfg_width = d[7:0];
		// back-to-back read of the same register
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== d) begin
			mismatches++;
			if (mismatches <= 10)
				$display("register 0x%0h read %08h, wrote %08h", a, prdata, d);
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_rows(input int first, input int final_row);
		int n;
		res_t want;
		for (int i = first; i <= final_row; i++) begin
			if (stim_rows[i].act == ROW_CFG) begin
				reg_write(stim_rows[i].addr, stim_rows[i].wdata);
			end else begin
				want = '{kind: stim_rows[i].kind, ch: stim_rows[i].want_ch, last: 1'b1};
				send_item(stim_rows[i].op, stim_rows[i].ch, stim_rows[i].typed, want, n);
			end
		end
	endtask

	// mostly well-formed sequence text: bases, N runs around the limit, blanks, record ends
	task automatic next_random(output logic o, output logic [7:0] c);
		int r;
		int bound;
		o = OP_CHAR;
		if (n_left > 0) begin
			n_left--;
			c = $urandom_range(0, 1) ? CH_UPPER_N : CH_LOWER_N;
			return;
		end
		r = $urandom_range(0, 99);
		if (r < eor_pct) begin
			o = OP_EOR;
			c = 8'($urandom_range(0, 255));
		end else if (r < eor_pct + 12) begin
			c = BLANKS[$urandom_range(0, 5)];
		end else if (r < eor_pct + 22) begin
			bound = (cfg_max_n < 16'd20) ? int'(cfg_max_n) + 3 : 24;
			n_left = $urandom_range(0, bound);
			c = CH_UPPER_N;
		end else begin
			c = BASES[$urandom_range(0, 9)];
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_out.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: kind=%0d char=%02h last=%0d",
						kind, out_char, last);
			end else begin
				head = expected_out.pop_front();
				if (kind !== head.kind || out_char !== head.ch || last !== head.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: want %0d/%02h/%0d got %0d/%02h/%0d",
							head.kind, head.ch, head.last, kind, out_char, last);
				end
			end
		end
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		int n;
		int produced;
		int target;
		int mn;
		int w;
		n_run = '0;
		line_fill = '0;
		err_stuck = 1'b0;
		cfg_max_n = MAX_N_RUN_RST;
		cfg_width = LINE_WIDTH_RST;
		set_pacing(PACE_BOTH);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_rows(0, OPEN_ROWS - 1);

		// long run of N well past a small limit, then a base that ends it
		reg_write(ADDR_MAX_N_RUN, 32'd4);
		reg_write(ADDR_LINE_WIDTH, 32'd75);
		set_pacing(PACE_NONE);
		for (int i = 0; i < N_BURST; i++)
			send_item(OP_CHAR, i[0] ? CH_LOWER_N : CH_UPPER_N, 1'b0, '0, n);
		send_item(OP_CHAR, "A", 1'b0, '0, n);

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin mn = 10; w = 75; end
				1: begin mn = 0; w = 1; end
				2: begin mn = 65535; w = 255; end
				3: begin mn = 3; w = 0; end
				5: begin mn = 1; w = 2; end
				default: begin
					mn = $urandom_range(0, 20);
					w = $urandom_range(3, 40);
				end
			endcase
			reg_write(ADDR_MAX_N_RUN, 32'(mn));
			reg_write(ADDR_LINE_WIDTH, 32'(w));
			set_pacing(pace_e'(p % 4));
			// wide lines need long records to ever wrap
			eor_pct = (w == 0 || w > 100) ? 0 : 10;
			target = (w == 0 || w > 100) ? 260 : 20;
			n_left = 0;
			produced = 0;
			while (produced < target) begin
				logic o;
				logic [7:0] c;
				next_random(o, c);
				send_item(o, c, 1'b0, '0, n);
				if (n > 0)
					produced++;
				if ($urandom_range(0, 63) == 0)
					drain_results();
			end
		end

		set_pacing(PACE_BOTH);
		run_rows(OPEN_ROWS, TOTAL_ROWS - 1);
		for (int i = 0; i < 30; i++)
			send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, '0, n);

		settle();
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
